>>> hdl/tcw_pkg.sv
// Shared types and constants of the text console writer.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    // Fixed field widths
    localparam int OP_W    = 2;
    localparam int CHAR_W  = 8;
    localparam int IDX_W   = 11;
    localparam int POS_W   = 11;
    localparam int COLOR_W = 8;
    localparam int CELL_W  = 16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

    // Attribute after reset: white on black
    localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h0F;

    // Memory sweep modes
    localparam logic [1:0] SWP_NONE = 2'd0;
    localparam logic [1:0] SWP_COPY = 2'd1;
    localparam logic [1:0] SWP_FILL = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic       load;        // capture the input item
        logic       put;         // put character, move cursor
        logic       rd_cell;     // read the addressed cell
        logic       home;        // cursor to top left
        logic       sweep_start; // sweep address to zero
        logic [1:0] sweep;       // sweep step this cycle
        logic       result;      // load the result register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            scroll_need;
        logic            idx_ok;
        logic            copy_last;
        logic            fill_last;
        logic            out_free;
    } t_sts;

endpackage

`default_nettype wire

>>> hdl/tcw_ctrl.sv
// Sequencing state machine of the text console writer.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl import tcw_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd,
    output logic      o_busy
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_COPY   = 3'd2;
    localparam logic [2:0] ST_FILL   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.sweep = SWP_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (i_sts.op)
                    OP_PUT: begin
                        o_cmd.put = 1'b1;
                        if (i_sts.scroll_need) begin
                            o_cmd.sweep_start = 1'b1;
                            n_state           = ST_COPY;
                        end else begin
                            n_state = ST_FINISH;
                        end
                    end
                    OP_CLEAR: begin
                        o_cmd.home        = 1'b1;
                        o_cmd.sweep_start = 1'b1;
                        n_state           = ST_FILL;
                    end
                    OP_READ: begin
                        o_cmd.rd_cell = i_sts.idx_ok;
                        n_state       = ST_FINISH;
                    end
                    default: begin
                        n_state = ST_FINISH;
                    end
                endcase
            end
            ST_COPY: begin
                // move rows up one cell per cycle
                o_cmd.sweep = SWP_COPY;
                if (i_sts.copy_last) begin
                    n_state = ST_FILL;
                end
            end
            ST_FILL: begin
                o_cmd.sweep = SWP_FILL;
                if (i_sts.fill_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.result = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

`ifndef NO_ASSERTIONS
    // A finished fill sweep always hands over to the result stage
    a_fill_to_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FILL && i_sts.fill_last) |=> (r_state == ST_FINISH))
        else $error("fill sweep did not end in result stage");

    // The row copy is always followed by the bottom row fill
    a_copy_to_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COPY && i_sts.copy_last) |=> (r_state == ST_FILL))
        else $error("row copy did not end in fill sweep");

    a_state_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state <= ST_FINISH)
        else $error("controller in an unknown state");
`endif

endmodule

`default_nettype wire

>>> hdl/tcw_dpath.sv
// Screen memory, cursor, color and result register of the text console writer.
`timescale 1ns / 1ps
`default_nettype none

module tcw_dpath import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_sts                    o_sts,
    input  wire logic [OP_W-1:0]    i_op,
    input  wire logic [CHAR_W-1:0]  i_char_code,
    input  wire logic [IDX_W-1:0]   i_cell_index,
    input  wire logic               i_cfg_valid,
    input  wire logic [COLOR_W-1:0] i_cfg_data,
    input  wire logic               i_out_stall,
    output logic                    o_out_valid,
    output logic [POS_W-1:0]        o_cursor_pos,
    output logic [CELL_W-1:0]       o_cell_data
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int WIDE_W     = ADDR_W + IDX_W;

    // Screen store
    logic [CELL_W-1:0] r_screen [CELL_COUNT];
    logic [CELL_W-1:0] r_rd_q;

    // Captured item
    logic [OP_W-1:0]   r_op;
    logic [CHAR_W-1:0] r_char;
    logic [IDX_W-1:0]  r_idx;

    // Cursor, color, sweep address
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [COLOR_W-1:0] r_color;
    logic [ADDR_W-1:0]  r_addr;

    // Write stage
    logic               r_wr_en;
    logic [ADDR_W-1:0]  r_wr_addr;
    logic               r_wr_copy;
    logic [CELL_W-1:0]  r_wr_val;

    // Result register
    logic               r_out_valid;
    logic [POS_W-1:0]   r_cursor_pos;
    logic [CELL_W-1:0]  r_cell_data;

    logic              col_last;
    logic              row_last;
    logic              is_nl;
    logic              is_cr;
    logic              put_wr;
    logic              idx_ok;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] cur_addr;
    logic [WIDE_W-1:0] idx_wide;
    logic [WIDE_W-1:0] pos_wide;
    logic [CELL_W-1:0] blank;

    assign col_last = (r_col == COL_W'(COLUMNS - 1));
    assign row_last = (r_row == ROW_W'(ROWS - 1));
    assign is_nl    = (r_char == CH_NEWLINE);
    assign is_cr    = (r_char == CH_RETURN);
    assign put_wr   = i_cmd.put && !is_nl && !is_cr;
    assign blank    = {r_color, CH_SPACE};
    assign cur_addr = ADDR_W'(r_row) * ADDR_W'(COLUMNS) + ADDR_W'(r_col);
    assign pos_wide = WIDE_W'(cur_addr);
    assign idx_wide = WIDE_W'(r_idx);
    assign idx_ok   = (idx_wide < WIDE_W'(CELL_COUNT));

    // Read port: copy source one row below, or the addressed cell
    assign rd_en   = (i_cmd.sweep == SWP_COPY) || i_cmd.rd_cell;
    assign rd_addr = (i_cmd.sweep == SWP_COPY) ? (r_addr + ADDR_W'(COLUMNS))
                                               : idx_wide[ADDR_W-1:0];

    // Status to controller
    always_comb begin
        o_sts.op          = r_op;
        o_sts.scroll_need = (r_op == OP_PUT) && row_last && (is_nl || (!is_cr && col_last));
        o_sts.idx_ok      = idx_ok;
        o_sts.copy_last   = (r_addr == ADDR_W'(CELL_COUNT - COLUMNS - 1));
        o_sts.fill_last   = (r_addr == ADDR_W'(CELL_COUNT - 1));
        o_sts.out_free    = !r_out_valid || !i_out_stall;
    end

    // Item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_char <= i_char_code;
            r_idx  <= i_cell_index;
        end
    end

    // Text color register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= COLOR_RESET;
        end else if (i_cfg_valid) begin
            r_color <= i_cfg_data;
        end
    end

    // Cursor; the row saturates on the last line, the scroll makes room
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.home) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.put) begin
            if (is_nl || (!is_cr && col_last)) begin
                r_col <= '0;
                if (!row_last) begin
                    r_row <= r_row + 1'b1;
                end
            end else if (is_cr) begin
                r_col <= '0;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // Sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (i_cmd.sweep_start) begin
            r_addr <= '0;
        end else if (i_cmd.sweep != SWP_NONE) begin
            r_addr <= r_addr + 1'b1;
        end
    end

    // Write stage: registered, so that copy data comes from the read port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_en <= 1'b0;
        end else begin
            r_wr_en <= put_wr || (i_cmd.sweep != SWP_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (put_wr) begin
            r_wr_addr <= cur_addr;
            r_wr_copy <= 1'b0;
            r_wr_val  <= {r_color, r_char};
        end else begin
            r_wr_addr <= r_addr;
            r_wr_copy <= (i_cmd.sweep == SWP_COPY);
            r_wr_val  <= blank;
        end
    end

    // Screen memory
    always_ff @(posedge i_clk) begin
        if (r_wr_en) begin
            r_screen[r_wr_addr] <= r_wr_copy ? r_rd_q : r_wr_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_q <= r_screen[rd_addr];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.result) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.result) begin
            r_cursor_pos <= pos_wide[POS_W-1:0];
            r_cell_data  <= ((r_op == OP_READ) && idx_ok) ? r_rd_q : '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cursor_pos = r_cursor_pos;
    assign o_cell_data  = r_cell_data;

`ifndef NO_ASSERTIONS
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= COL_W'(COLUMNS - 1)) && (r_row <= ROW_W'(ROWS - 1)))
        else $error("cursor outside the screen");

    a_result_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.result |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over an untaken item");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_en |-> (r_wr_addr <= ADDR_W'(CELL_COUNT - 1)))
        else $error("screen write outside the store");
`endif

endmodule

`default_nettype wire

>>> hdl/text_console_writer.sv
// Top level of the text console writer: controller, datapath and configuration port.
`timescale 1ns / 1ps
`default_nettype none

// Text-mode console with a ROWS x COLUMNS screen store of 16-bit cells (attribute
// high, character low) and a cursor. Ops: put character (newline, carriage return,
// or write in the current color and advance, scrolling at the bottom), clear the
// screen, read one cell. Every item returns one result with the linear cursor
// position and, for a read, the cell. A put, read or unused op passes through the
// execute and result states before the next item is accepted; a put that scrolls
// also copies the rows up one cell per cycle, then fills the bottom row; a clear
// fills the whole screen. The screen memory moves one cell per cycle through its
// single write port. The store is not cleared at reset: cells read before they are
// written or cleared return undefined data. The color register may be written at
// any time the block is idle; cfg ready is always high.

module text_console_writer import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [OP_W-1:0]    i_op,
    input  wire logic [CHAR_W-1:0]  i_char_code,
    input  wire logic [IDX_W-1:0]   i_cell_index,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [POS_W-1:0]        o_cursor_pos,
    output logic [CELL_W-1:0]       o_cell_data,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [COLOR_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;
    logic busy;

    // Sequencer
    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    // Storage and arithmetic
    tcw_dpath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_op         (i_op),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .i_cfg_valid  (i_cfg_valid && o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_cursor_pos (o_cursor_pos),
        .o_cell_data  (o_cell_data)
    );

    // New items only while idle; color writes always taken
    assign o_in_stall  = busy;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

>>> tb/sv/tb_text_console_writer.sv
// Self-checking testbench for the text console writer: stimulus, screen predictor, result checks.
`timescale 1ns / 1ps

module tb_text_console_writer;
    import tcw_pkg::*;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int CELLS       = ROWS * COLUMNS;
    localparam int CYCLE_LIMIT = 2000000;

    // op 3 has no function; the block only reports the cursor
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
    } console_cmd_t;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [CELL_W-1:0] cdata;
    } cursor_cell_t;

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #5 i_clk = ~i_clk;

    // Block ports
    logic               in_valid_r = 1'b0;
    logic [OP_W-1:0]    in_op_r    = '0;
    logic [CHAR_W-1:0]  in_char_r  = '0;
    logic [IDX_W-1:0]   in_idx_r   = '0;
    logic               out_stall_r = 1'b0;
    logic               cfg_valid_r = 1'b0;
    logic [COLOR_W-1:0] cfg_data_r  = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [POS_W-1:0]   o_cursor_pos;
    logic [CELL_W-1:0]  o_cell_data;
    logic               o_cfg_ready;

    text_console_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid_r),
        .o_in_stall   (o_in_stall),
        .i_op         (in_op_r),
        .i_char_code  (in_char_r),
        .i_cell_index (in_idx_r),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (out_stall_r),
        .o_cursor_pos (o_cursor_pos),
        .o_cell_data  (o_cell_data),
        .i_cfg_valid  (cfg_valid_r),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (cfg_data_r)
    );

    // Commands waiting to be sent, and results the screen predictor owes
    console_cmd_t commands_todo[$];
    cursor_cell_t cursor_cells_due[$];

    // Predicted console state
    logic [CELL_W-1:0]  screen_img [CELLS];
    logic [COLOR_W-1:0] color_reg = COLOR_RESET;
    int cur_col = 0;
    int cur_row = 0;

    // Run statistics
    int mismatches    = 0;
    int stray_results = 0;
    int puts_seen     = 0;
    int clears_seen   = 0;
    int reads_seen    = 0;
    int scrolls_seen  = 0;
    int colors_used   = 1;
    int cycle_count   = 0;

    // Idle draws: a steady stretch means no waiting at all
    bit in_steady  = 1'b0;
    bit out_steady = 1'b0;
    int in_gap     = 0;
    int out_hold   = 0;
    int draw_n;
    int hold_n;

    function automatic int draw_gap(inout bit steady);
        if ($urandom_range(0, 15) == 0) steady = !steady;
        return steady ? 0 : int'($urandom_range(0, 3));
    endfunction

    // Apply one command to the predicted console and queue its result
    task automatic console_step(input console_cmd_t c);
        cursor_cell_t r;
        int i;
        r.cdata = '0;
        case (c.op)
            OP_PUT: begin
                puts_seen++;
                if (c.ch == CH_NEWLINE) begin
                    cur_col = 0;
                    cur_row++;
                end else if (c.ch == CH_RETURN) begin
                    cur_col = 0;
                end else begin
                    screen_img[cur_row * COLUMNS + cur_col] = {color_reg, c.ch};
                    cur_col++;
                    if (cur_col >= COLUMNS) begin
                        cur_col = 0;
                        cur_row++;
                    end
                end
                // past the bottom: shift rows up, blank the last row
                if (cur_row >= ROWS) begin
                    scrolls_seen++;
                    for (i = 0; i < CELLS - COLUMNS; i++)
                        screen_img[i] = screen_img[i + COLUMNS];
                    for (i = CELLS - COLUMNS; i < CELLS; i++)
                        screen_img[i] = {color_reg, CH_SPACE};
                    cur_row = ROWS - 1;
                end
            end
            OP_CLEAR: begin
                clears_seen++;
                for (i = 0; i < CELLS; i++)
                    screen_img[i] = {color_reg, CH_SPACE};
                cur_col = 0;
                cur_row = 0;
            end
            OP_READ: begin
                reads_seen++;
                if (int'(c.idx) < CELLS) r.cdata = screen_img[c.idx];
            end
            default: ;
        endcase
        r.pos = POS_W'(cur_row * COLUMNS + cur_col);
        cursor_cells_due.push_back(r);
    endtask

    // Command driver: present the next item after a random gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid_r <= 1'b0;
            in_gap     <= 0;
        end else if (in_valid_r && !o_in_stall) begin
            console_step('{op: in_op_r, ch: in_char_r, idx: in_idx_r});
            draw_n = draw_gap(in_steady);
            if (draw_n == 0 && commands_todo.size() != 0) begin
                {in_op_r, in_char_r, in_idx_r} <= commands_todo.pop_front();
            end else begin
                in_valid_r <= 1'b0;
                in_gap     <= draw_n;
            end
        end else if (!in_valid_r) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
            end else if (commands_todo.size() != 0) begin
                {in_op_r, in_char_r, in_idx_r} <= commands_todo.pop_front();
                in_valid_r <= 1'b1;
            end
        end
    end

    // Result monitor: check each accepted item, then stall the next one a while
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall_r <= 1'b0;
            out_hold    <= 0;
        end else if (o_out_valid && !out_stall_r) begin
            if (cursor_cells_due.size() == 0) begin
                stray_results++;
                $display("ERROR: result with nothing predicted: pos %0d cell %h",
                         o_cursor_pos, o_cell_data);
            end else begin
                cursor_cell_t want;
                want = cursor_cells_due.pop_front();
                if (o_cursor_pos !== want.pos || o_cell_data !== want.cdata) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: pos exp %0d got %0d, cell exp %h got %h",
                                 want.pos, o_cursor_pos, want.cdata, o_cell_data);
                end
            end
            hold_n = draw_gap(out_steady);
            out_hold    <= hold_n;
            out_stall_r <= (hold_n != 0);
        end else if (o_out_valid && out_stall_r) begin
            if (out_hold <= 1) out_stall_r <= 1'b0;
            out_hold <= out_hold - 1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic push_cmd(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                            input logic [IDX_W-1:0] idx);
        commands_todo.push_back('{op: op, ch: ch, idx: idx});
    endtask

    // Wait until nothing is queued, in flight or owed; sampled away from the
    // clock edge so the driver's updates are settled
    task automatic wait_idle();
        @(negedge i_clk);
        while (commands_todo.size() != 0 || in_valid_r || cursor_cells_due.size() != 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_color(input logic [COLOR_W-1:0] value);
        @(posedge i_clk);
        cfg_valid_r <= 1'b1;
        cfg_data_r  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        color_reg = value;
        colors_used++;
        cfg_valid_r <= 1'b0;
    endtask

    // Newline-heavy mix so the cursor reaches the bottom and scrolls
    task automatic queue_random_text(input int count);
        int made;
        int pick;
        int burst;
        made = 0;
        while (made < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                push_cmd(OP_PUT, CH_NEWLINE, IDX_W'($urandom_range(0, 2047)));
                made++;
            end else if (pick < 40) begin
                push_cmd(OP_PUT, CH_RETURN, IDX_W'($urandom_range(0, 2047)));
                made++;
            end else if (pick < 65) begin
                burst = $urandom_range(1, 6);
                repeat (burst) push_cmd(OP_PUT, CHAR_W'($urandom_range(0, 255)),
                                        IDX_W'($urandom_range(0, 2047)));
                made += burst;
            end else if (pick < 90) begin
                push_cmd(OP_READ, CHAR_W'($urandom_range(0, 255)),
                         IDX_W'($urandom_range(0, 2047)));
                made++;
            end else if (pick < 97) begin
                push_cmd(OP_UNUSED, CHAR_W'($urandom_range(0, 255)),
                         IDX_W'($urandom_range(0, 2047)));
                made++;
            end else begin
                push_cmd(OP_CLEAR, CHAR_W'($urandom_range(0, 255)),
                         IDX_W'($urandom_range(0, 2047)));
                made++;
            end
        end
    endtask

    initial begin
        // Directed: cells written before any clear are read back only where written
        push_cmd(OP_PUT, 8'h00, 11'h7FF);
        push_cmd(OP_PUT, 8'hFF, 11'h000);
        push_cmd(OP_PUT, 8'h41, 11'h555);
        push_cmd(OP_READ, 8'hFF, 11'd0);
        push_cmd(OP_READ, 8'h00, 11'd1);
        push_cmd(OP_READ, 8'h00, 11'd2);
        push_cmd(OP_READ, 8'h00, IDX_W'(CELLS));
        push_cmd(OP_READ, 8'hAA, 11'h7FF);
        push_cmd(OP_UNUSED, 8'hFF, 11'h7FF);
        push_cmd(OP_PUT, CH_RETURN, 11'h000);
        push_cmd(OP_PUT, 8'h42, 11'h000);
        push_cmd(OP_READ, 8'h00, 11'd0);
        push_cmd(OP_CLEAR, 8'h55, 11'h2AA);
        push_cmd(OP_READ, 8'h00, IDX_W'(CELLS - 1));
        push_cmd(OP_PUT, CH_NEWLINE, 11'h000);
        push_cmd(OP_PUT, 8'h7E, 11'h000);
        push_cmd(OP_READ, 8'h00, IDX_W'(COLUMNS));
        push_cmd(OP_PUT, 8'h80, 11'h400);
        push_cmd(OP_READ, 8'h00, IDX_W'(COLUMNS + 1));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Black on black, random text
        wait_idle();
        write_color(8'h00);
        queue_random_text(10);

        // All ones color; one line long enough to wrap, then random text
        wait_idle();
        write_color(8'hFF);
        push_cmd(OP_PUT, CH_RETURN, 11'h000);
        repeat (COLUMNS + 1)
            push_cmd(OP_PUT, CHAR_W'($urandom_range(14, 255)), IDX_W'($urandom_range(0, 2047)));
        queue_random_text(5);

        // Two random colors; a run of newlines forces scrolling at the bottom
        wait_idle();
        write_color(COLOR_W'($urandom_range(1, 254)));
        repeat (ROWS) push_cmd(OP_PUT, CH_NEWLINE, 11'h000);
        queue_random_text(10);
        wait_idle();
        write_color(COLOR_W'($urandom_range(0, 255)));
        queue_random_text(5);

        wait_idle();
        repeat (CELLS + 16) @(posedge i_clk);

        $display("Ran %0d puts, %0d clears, %0d reads with %0d scrolls", puts_seen,
                 clears_seen, reads_seen, scrolls_seen);
        $display("under %0d text colors; %0d mismatches, %0d unexpected, %0d missing",
                 colors_used, mismatches, stray_results, cursor_cells_due.size());
        if (mismatches == 0 && stray_results == 0 && cursor_cells_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> text_console_writer.f
hdl/tcw_pkg.sv
hdl/tcw_ctrl.sv
hdl/tcw_dpath.sv
hdl/text_console_writer.sv
tb/sv/tb_text_console_writer.sv
